// ----- hdl/kpe_pkg.sv -----
// Package for the k-permutation enumerator: function codes, fixed field
// widths, sequencer state and pending-operation types.
// No dependencies.
`default_nettype none

package kpe_pkg;

	localparam int VAL_W  = 32;
	localparam int FUNC_W = 2;
	localparam int PICK_W = 4;

	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_NEXT   = 2'd2;

	localparam logic [PICK_W-1:0] MAX_PICK   = 4'd8;
	localparam logic [PICK_W-1:0] PICK_RESET = 4'd3;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_UNDO    = 10'b00_0000_0010,
		S_APPLY   = 10'b00_0000_0100,
		S_ADV     = 10'b00_0000_1000,
		S_ADV_CHK = 10'b00_0001_0000,
		S_SWA     = 10'b00_0010_0000,
		S_SWB     = 10'b00_0100_0000,
		S_SWC     = 10'b00_1000_0000,
		S_SWD     = 10'b01_0000_0000,
		S_EMIT    = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_CONFIG = 2'd2
	} op_t;

endpackage

`default_nettype wire

// ----- hdl/kpe_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module kpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- hdl/k_permutation_enumerator.sv -----
// Top level of the k-permutation enumerator: command port, configuration
// port, swap sequencer and level stack. Uses kpe_pkg and kpe_ram.
`default_nettype none

// The block stores up to MAX_ELEMS signed 32-bit values and, on each request,
// hands out the next ordered selection of pick_count of them in the order of
// recursive swap backtracking. A command is transferred when start is high
// and busy is low. Results come out one per cycle with res_valid high for
// exactly one cycle each; the receiver cannot stall them, so it must take
// every result in the cycle it is shown. A selection arrives as pick_count
// consecutive results with last set on the final one; an exhausted
// enumeration answers with a single result that has done_res and last set and
// a zero value. An append to a full list answers with a single result that
// has overflow and last set. Successful appends, clears and unknown codes
// give no result.
// Sequencing: all element reordering goes through one swap sequence on the
// element RAM, which has one read and one write port; a swap of two distinct
// slots runs the states S_SWA, S_SWB, S_SWC and S_SWD, and a swap of a slot
// with itself is skipped. A request that advances the enumeration walks down
// the stack through S_ADV and S_ADV_CHK for each visited level, does every
// non-trivial swap (the undo swap of every visited level and the forward swap
// of the level that advances), and then emits one element per cycle; the
// last result is shown in the same cycle that busy drops. The first request
// with a valid pick_count goes from idle straight to emission with no swaps.
// An append, a clear or a configuration write first undoes the swaps of a
// running enumeration, level by level, and then applies the change in
// S_APPLY. An exhausted enumeration answers straight from the idle state.
module k_permutation_enumerator
	import kpe_pkg::*;
#(
	parameter int MAX_ELEMS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Command channel
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [VAL_W-1:0]  value,
	// Configuration channel: pick_count
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [PICK_W-1:0] cfg_data,
	// Result strobe and fields
	output logic                   res_valid,
	output logic [VAL_W-1:0]       value_res,
	output logic                   last,
	output logic                   done_res,
	output logic                   overflow
);

	// Index width addresses one slot; count width also holds MAX_ELEMS itself.
	localparam int IW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);
	localparam int KW = (CW > PICK_W) ? CW : PICK_W;

	state_t             state_q;
	state_t             ret_q;
	op_t                op_q;
	logic [PICK_W-1:0]  pick_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      cur_q;
	logic               started_q;
	logic               finished_q;
	logic [IW-1:0]      idx_q [MAX_ELEMS];
	logic [IW-1:0]      lvl_q;
	logic [IW-1:0]      emit_q;
	logic [IW-1:0]      swa_q;
	logic [IW-1:0]      swb_q;
	logic [VAL_W-1:0]   tmp_q;
	logic [VAL_W-1:0]   val_q;

	// Result stage registered behind the sequencer, in step with
	// the RAM's registered read.
	logic               res_v_s1;
	logic               res_sel_s1;
	logic               res_last_s1;
	logic               res_done_s1;
	logic               res_ovf_s1;

	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [VAL_W-1:0]   ram_wdata;
	logic [IW-1:0]      ram_raddr;
	logic [VAL_W-1:0]   ram_rdata;

	logic [IW-1:0]      idx_raddr;
	logic [IW-1:0]      idx_rd;
	logic [IW-1:0]      undo_lvl;
	logic [CW-1:0]      idx_next;
	logic               pick_bad;
	logic               cmd_take;
	logic               cfg_take;

	kpe_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_ELEMS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign cmd_take  = start && !busy;
	assign cfg_take  = cfg_valid && cfg_ready;

	// The level being unwound by a restart is the top of the stack; an
	// advance walks its own level register.
	assign undo_lvl  = IW'(cur_q - 1'b1);
	assign idx_raddr = (state_q == S_UNDO) ? undo_lvl : lvl_q;
	assign idx_rd    = idx_q[idx_raddr];
	assign idx_next  = CW'(idx_rd) + 1'b1;

	// A selection size of zero, above the hardware limit, or above the
	// number of stored elements finishes the enumeration at once.
	assign pick_bad = (pick_q == '0) || (pick_q > MAX_PICK) ||
		(KW'(pick_q) > KW'(count_q)) || (KW'(pick_q) > KW'(MAX_ELEMS));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = swa_q;
		ram_wdata = ram_rdata;
		ram_raddr = swa_q;
		case (state_q)
			S_SWB: begin
				ram_raddr = swb_q;
			end
			S_SWC: begin
				ram_we    = 1'b1;
				ram_waddr = swa_q;
				ram_wdata = ram_rdata;
			end
			S_SWD: begin
				ram_we    = 1'b1;
				ram_waddr = swb_q;
				ram_wdata = tmp_q;
			end
			S_APPLY: begin
				ram_we    = (op_q == OP_APPEND) && (count_q < CW'(MAX_ELEMS));
				ram_waddr = IW'(count_q);
				ram_wdata = val_q;
			end
			S_EMIT: begin
				ram_raddr = emit_q;
			end
			default: begin
				ram_raddr = swa_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			op_q        <= OP_CLEAR;
			pick_q      <= PICK_RESET;
			count_q     <= '0;
			cur_q       <= '0;
			started_q   <= 1'b0;
			finished_q  <= 1'b0;
			lvl_q       <= '0;
			emit_q      <= '0;
			swa_q       <= '0;
			swb_q       <= '0;
			tmp_q       <= '0;
			res_v_s1    <= 1'b0;
			res_sel_s1  <= 1'b0;
			res_last_s1 <= 1'b0;
			res_done_s1 <= 1'b0;
			res_ovf_s1  <= 1'b0;
			for (int m = 0; m < MAX_ELEMS; m++) begin
				idx_q[m] <= '0;
			end
		end else begin
			res_v_s1    <= 1'b0;
			res_sel_s1  <= 1'b0;
			res_last_s1 <= 1'b0;
			res_done_s1 <= 1'b0;
			res_ovf_s1  <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (cfg_take) begin
						pick_q  <= cfg_data;
						op_q    <= OP_CONFIG;
						state_q <= S_UNDO;
					end else if (cmd_take) begin
						if (func == FUNC_APPEND) begin
							op_q    <= OP_APPEND;
							state_q <= S_UNDO;
						end else if (func == FUNC_CLEAR) begin
							op_q    <= OP_CLEAR;
							state_q <= S_UNDO;
						end else if (func == FUNC_NEXT) begin
							if (!started_q) begin
								started_q <= 1'b1;
								if (pick_bad) begin
									finished_q  <= 1'b1;
									cur_q       <= '0;
									res_v_s1    <= 1'b1;
									res_last_s1 <= 1'b1;
									res_done_s1 <= 1'b1;
								end else begin
									// Identity stack: every level starts at its own slot.
									cur_q  <= CW'(pick_q);
									emit_q <= '0;
									for (int m = 0; m < MAX_ELEMS; m++) begin
										idx_q[m] <= IW'(m);
									end
									state_q <= S_EMIT;
								end
							end else if (!finished_q) begin
								lvl_q   <= undo_lvl;
								state_q <= S_ADV;
							end else begin
								res_v_s1    <= 1'b1;
								res_last_s1 <= 1'b1;
								res_done_s1 <= 1'b1;
							end
						end
					end
				end

				S_UNDO: begin
					// Unwind the stack from the top level down; cur_q is zero
					// whenever nothing is running.
					if (cur_q != '0) begin
						cur_q   <= cur_q - 1'b1;
						swa_q   <= undo_lvl;
						swb_q   <= idx_rd;
						ret_q   <= S_UNDO;
						state_q <= (undo_lvl == idx_rd) ? S_UNDO : S_SWA;
					end else begin
						state_q <= S_APPLY;
					end
				end

				S_APPLY: begin
					started_q  <= 1'b0;
					finished_q <= 1'b0;
					for (int m = 0; m < MAX_ELEMS; m++) begin
						idx_q[m] <= '0;
					end
					case (op_q)
						OP_APPEND: begin
							if (count_q < CW'(MAX_ELEMS)) begin
								count_q <= count_q + 1'b1;
							end else begin
								res_v_s1    <= 1'b1;
								res_last_s1 <= 1'b1;
								res_ovf_s1  <= 1'b1;
							end
						end
						OP_CLEAR: begin
							count_q <= '0;
						end
						default: begin
							count_q <= count_q;
						end
					endcase
					state_q <= S_IDLE;
				end

				S_ADV: begin
					// Undo this level's swap before trying its next choice.
					swa_q   <= lvl_q;
					swb_q   <= idx_rd;
					ret_q   <= S_ADV_CHK;
					state_q <= (lvl_q == idx_rd) ? S_ADV_CHK : S_SWA;
				end

				S_ADV_CHK: begin
					if (idx_next < count_q) begin
						idx_q[lvl_q] <= IW'(idx_next);
						for (int m = 0; m < MAX_ELEMS; m++) begin
							if (m > int'(lvl_q)) begin
								idx_q[m] <= IW'(m);
							end
						end
						emit_q  <= '0;
						swa_q   <= lvl_q;
						swb_q   <= IW'(idx_next);
						ret_q   <= S_EMIT;
						state_q <= S_SWA;
					end else if (lvl_q == '0) begin
						// Every level is exhausted and the store is back in load order.
						finished_q  <= 1'b1;
						cur_q       <= '0;
						res_v_s1    <= 1'b1;
						res_last_s1 <= 1'b1;
						res_done_s1 <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						lvl_q   <= lvl_q - 1'b1;
						state_q <= S_ADV;
					end
				end

				S_SWA: begin
					state_q <= S_SWB;
				end

				S_SWB: begin
					tmp_q   <= ram_rdata;
					state_q <= S_SWC;
				end

				S_SWC: begin
					state_q <= S_SWD;
				end

				S_SWD: begin
					state_q <= ret_q;
				end

				S_EMIT: begin
					res_v_s1    <= 1'b1;
					res_sel_s1  <= 1'b1;
					res_last_s1 <= (CW'(emit_q) + 1'b1 == cur_q);
					if (CW'(emit_q) + 1'b1 == cur_q) begin
						state_q <= S_IDLE;
					end else begin
						emit_q <= emit_q + 1'b1;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The appended value is held only for the write after the unwind.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			val_q <= value;
		end
	end

	assign res_valid = res_v_s1;
	assign value_res = res_sel_s1 ? ram_rdata : '0;
	assign last      = res_last_s1;
	assign done_res  = res_done_s1;
	assign overflow  = res_ovf_s1;

endmodule

`default_nettype wire

// ----- hdl/kpe_checker.sv -----
// Port-level checker for the k-permutation enumerator, with its bind.
// Uses kpe_pkg; attaches to k_permutation_enumerator.
`default_nettype none

module kpe_checker
	import kpe_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic [FUNC_W-1:0] func,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready,
	input wire logic              res_valid,
	input wire logic [VAL_W-1:0]  value_res,
	input wire logic              last,
	input wire logic              done_res,
	input wire logic              overflow
);

	// A done result is a single-result answer with a zero value.
	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> last && !overflow && (value_res == '0))
		else $error("done result malformed");

	// An overflow result is a single-result answer with a zero value.
	a_ovf_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && overflow |-> last && !done_res && (value_res == '0))
		else $error("overflow result malformed");

	// A request either answers in the next cycle or keeps the block busy.
	a_next_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_NEXT) |=> busy || res_valid)
		else $error("request neither answered nor in progress");

	// A configuration transfer starts the unwind of the enumeration.
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy)
		else $error("configuration transfer did not start the unwind");

endmodule

bind k_permutation_enumerator kpe_checker u_kpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.func      (func),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.res_valid (res_valid),
	.value_res (value_res),
	.last      (last),
	.done_res  (done_res),
	.overflow  (overflow)
);

`default_nettype wire

// ----- bench/tb_k_permutation_enumerator.sv -----
// Self-checking testbench for k_permutation_enumerator: directed table, then random load/request
// sequences under several pick_count settings, checked against an in-bench permutation predictor.
// Depends on kpe_pkg and the k_permutation_enumerator RTL only.
module tb_k_permutation_enumerator;
	import kpe_pkg::*;

	localparam int NSLOT = 8;
	// Worst-case time for the block to unwind every level and finish a command that has
	// no result, used before a configuration write and at the end of the run.
	localparam int SETTLE = 48;
	localparam int RANDOM_ITEMS = 350;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	// One result word as it leaves the block.
	typedef struct {
		logic [VAL_W-1:0] val;
		logic             fin;
		logic             done;
		logic             ovf;
	} sel_word_t;

	// How a directed row is checked: against the predictor, or with a result typed in.
	typedef enum {CHK_MODEL, CHK_NONE, CHK_DONE, CHK_OVERFLOW} row_chk_t;

	typedef struct {
		logic [FUNC_W-1:0] f;
		logic [VAL_W-1:0]  v;
		row_chk_t          chk;
	} cmd_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [FUNC_W-1:0] func = FUNC_CLEAR;
	logic [VAL_W-1:0]  value = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [PICK_W-1:0] cfg_data = '0;
	logic              res_valid;
	logic [VAL_W-1:0]  value_res;
	logic              last;
	logic              done_res;
	logic              overflow;

	always #2 clk = ~clk;

	k_permutation_enumerator #(
		.MAX_ELEMS(NSLOT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.value    (value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.res_valid(res_valid),
		.value_res(value_res),
		.last     (last),
		.done_res (done_res),
		.overflow (overflow)
	);

	// Directed part. The first rows run with the reset pick_count of three. Rows whose
	// answer is obvious carry it typed in; the permutation rows go through the predictor.
	cmd_row_t directed [25] = '{
		'{FUNC_NEXT,   32'h0000_0000, CHK_DONE},      // empty list answers done at once
		'{FUNC_NEXT,   32'hFFFF_FFFF, CHK_DONE},      // and keeps answering done
		'{FUNC_UNUSED, 32'hFFFF_FFFF, CHK_NONE},      // unknown code is dropped
		'{FUNC_APPEND, 32'h8000_0000, CHK_NONE},
		'{FUNC_APPEND, 32'h7FFF_FFFF, CHK_NONE},
		'{FUNC_NEXT,   32'h0000_0000, CHK_DONE},      // pick_count above element count
		'{FUNC_APPEND, 32'h0000_0000, CHK_NONE},
		'{FUNC_NEXT,   32'h0000_0000, CHK_MODEL},     // all six orderings of three values
		'{FUNC_NEXT,   32'h0000_0000, CHK_MODEL},
		'{FUNC_NEXT,   32'h0000_0000, CHK_MODEL},
		'{FUNC_NEXT,   32'h0000_0000, CHK_MODEL},
		'{FUNC_NEXT,   32'h0000_0000, CHK_MODEL},
		'{FUNC_NEXT,   32'h0000_0000, CHK_MODEL},
		'{FUNC_NEXT,   32'h0000_0000, CHK_MODEL},     // enumeration runs out here
		'{FUNC_NEXT,   32'h5555_5555, CHK_DONE},
		'{FUNC_APPEND, 32'hFFFF_FFFF, CHK_NONE},      // append after exhaustion restarts
		'{FUNC_NEXT,   32'h0000_0000, CHK_MODEL},
		'{FUNC_APPEND, 32'h5555_5555, CHK_NONE},      // append in mid-enumeration undoes swaps
		'{FUNC_APPEND, 32'hAAAA_AAAA, CHK_NONE},
		'{FUNC_APPEND, 32'h0000_0001, CHK_NONE},
		'{FUNC_APPEND, 32'hFFFF_FFFE, CHK_NONE},      // list is full now
		'{FUNC_APPEND, 32'h1234_5678, CHK_OVERFLOW},  // refused append
		'{FUNC_NEXT,   32'h0000_0000, CHK_MODEL},
		'{FUNC_CLEAR,  32'hFFFF_FFFF, CHK_NONE},
		'{FUNC_NEXT,   32'h0000_0000, CHK_DONE}       // cleared list answers done
	};

	// Predictor state: the element slots in their current swapped order, the per-level
	// index stack and the enumeration flags, plus the pick_count register.
	logic [VAL_W-1:0]  sel_store [NSLOT];
	logic [3:0]        sel_idx [NSLOT];
	int                sel_count = 0;
	int                sel_depth = 0;
	bit                walking = 1'b0;
	bit                exhausted = 1'b0;
	logic [PICK_W-1:0] pick_cfg = PICK_RESET;

	sel_word_t step_out[$];   // results of the command just predicted
	sel_word_t expect_q[$];   // results still owed by the block, oldest first

	int  errors = 0;
	int  cmds_sent = 0;
	int  results_seen = 0;
	int  picks_written = 0;
	bit  quiet = 1'b0;        // when set, the command side never idles

	initial begin
		foreach (sel_store[i]) sel_store[i] = '0;
		foreach (sel_idx[i]) sel_idx[i] = '0;
	end

	function automatic void exchange_slots(int a, int b);
		logic [VAL_W-1:0] t;
		t = sel_store[a];
		sel_store[a] = sel_store[b];
		sel_store[b] = t;
	endfunction

	// Leaving a running enumeration undoes its swaps, deepest level first, so that the
	// slots hold the load order again.
	function automatic void rewind_walk();
		if (walking && !exhausted) begin
			for (int l = sel_depth; l > 0; l--)
				exchange_slots(l - 1, int'(sel_idx[l - 1]));
		end
		walking = 1'b0;
		exhausted = 1'b0;
		sel_depth = 0;
		foreach (sel_idx[i]) sel_idx[i] = '0;
	endfunction

	function automatic void predict_cmd(logic [FUNC_W-1:0] f, logic [VAL_W-1:0] v);
		int k;
		int l;
		bit moved;
		step_out.delete();
		case (f)
			FUNC_APPEND: begin
				rewind_walk();
				if (sel_count >= NSLOT) begin
					step_out.push_back('{'0, 1'b1, 1'b0, 1'b1});
				end else begin
					sel_store[sel_count] = v;
					sel_count++;
				end
			end
			FUNC_CLEAR: begin
				rewind_walk();
				sel_count = 0;
			end
			FUNC_NEXT: begin
				if (!walking) begin
					// First request: an impossible pick_count is exhausted straight away.
					walking = 1'b1;
					k = int'(pick_cfg);
					if (k == 0 || k > int'(MAX_PICK) || k > sel_count) begin
						exhausted = 1'b1;
						sel_depth = 0;
					end else begin
						sel_depth = k;
						for (int m = 0; m < k; m++) sel_idx[m] = 4'(m);
					end
				end else if (!exhausted) begin
					// Pop levels, undoing each swap, until one level can move its index on;
					// that level swaps in its next element and the levels below it reset.
					k = sel_depth;
					moved = 1'b0;
					l = k;
					while (l > 0) begin
						l--;
						exchange_slots(l, int'(sel_idx[l]));
						if (int'(sel_idx[l]) + 1 < sel_count) begin
							sel_idx[l] = sel_idx[l] + 4'd1;
							exchange_slots(l, int'(sel_idx[l]));
							for (int m = l + 1; m < k; m++) sel_idx[m] = 4'(m);
							moved = 1'b1;
							break;
						end
					end
					if (!moved) begin
						exhausted = 1'b1;
						sel_depth = 0;
					end
				end
				if (exhausted) begin
					step_out.push_back('{'0, 1'b1, 1'b1, 1'b0});
				end else begin
					for (int m = 0; m < sel_depth; m++)
						step_out.push_back('{sel_store[m], 1'(m + 1 == sel_depth), 1'b0, 1'b0});
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		if (errors < 40)
			$display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	// Mostly back-to-back, sometimes a short gap, now and then a long pause.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Values lean on the extremes so every bit is seen at both levels.
	function automatic logic [VAL_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// One command transfer. Start is left high after the transfer so that a following
	// command can go out on the next edge; whoever pauses afterwards lowers it.
	task automatic send_cmd(logic [FUNC_W-1:0] f, logic [VAL_W-1:0] v, row_chk_t chk);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		value <= v;
		do @(posedge clk); while (busy);
		predict_cmd(f, v);
		case (chk)
			CHK_MODEL: foreach (step_out[i]) expect_q.push_back(step_out[i]);
			CHK_DONE: expect_q.push_back('{'0, 1'b1, 1'b1, 1'b0});
			CHK_OVERFLOW: expect_q.push_back('{'0, 1'b1, 1'b0, 1'b1});
			default: ;
		endcase
		if (f != FUNC_UNUSED) cmds_sent++;
	endtask

	// Stop issuing commands, wait for every owed result, then give the block time to
	// finish any command that produces no result.
	task automatic drain();
		start <= 1'b0;
		while (expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_pick(logic [PICK_W-1:0] v);
		int gap;
		drain();
		gap = idle_len();
		repeat (gap) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rewind_walk();
		pick_cfg = v;
		picks_written++;
	endtask

	// Most sequences are a clean load followed by requests, sometimes walking the whole
	// enumeration out and past its end; the rest is loose noise on every code or bare requests.
	task automatic run_sequence();
		int kind;
		int n;
		int reqs;
		kind = $urandom_range(0, 9);
		if (kind <= 6) begin
			send_cmd(FUNC_CLEAR, rand_word(), CHK_MODEL);
			if (pick_cfg == MAX_PICK || $urandom_range(0, 7) == 0)
				n = $urandom_range(6, 10);
			else
				n = $urandom_range(1, 5);
			repeat (n) send_cmd(FUNC_APPEND, rand_word(), CHK_MODEL);
			reqs = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 12);
			repeat (reqs) begin
				if ($urandom_range(0, 19) == 0)
					send_cmd(FUNC_APPEND, rand_word(), CHK_MODEL);
				send_cmd(FUNC_NEXT, rand_word(), CHK_MODEL);
			end
		end else if (kind <= 8) begin
			repeat (6) send_cmd(FUNC_W'($urandom_range(0, 3)), rand_word(), CHK_MODEL);
		end else begin
			repeat (3) send_cmd(FUNC_NEXT, rand_word(), CHK_MODEL);
		end
	endtask

	// Results cannot be held off, so every strobe is taken and checked on the edge that
	// ends its cycle.
	always @(posedge clk) begin
		sel_word_t e;
		if (arst_n && res_valid) begin
			results_seen++;
			if (expect_q.size() == 0) begin
				report_mismatch("unexpected result, value_res", value_res, '0);
			end else begin
				e = expect_q.pop_front();
				if (value_res !== e.val) report_mismatch("value_res", value_res, e.val);
				if (last !== e.fin) report_mismatch("last", 32'(last), 32'(e.fin));
				if (done_res !== e.done) report_mismatch("done_res", 32'(done_res), 32'(e.done));
				if (overflow !== e.ovf) report_mismatch("overflow", 32'(overflow), 32'(e.ovf));
			end
		end
	end

	initial begin
		int base;
		int phase;
		int pick_plan [4];
		pick_plan = '{1, 8, 0, 15};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_cmd(directed[i].f, directed[i].v, directed[i].chk);
		base = cmds_sent;

		// Each phase starts with a pick_count write from an idle block: first the
		// extremes and the out-of-range codes, then mostly small settings.
		phase = 0;
		while (cmds_sent - base < RANDOM_ITEMS) begin
			if (phase < 4)
				write_pick(PICK_W'(pick_plan[phase]));
			else if ($urandom_range(0, 9) < 7)
				write_pick(PICK_W'($urandom_range(1, 4)));
			else
				write_pick(PICK_W'($urandom_range(0, 15)));
			quiet = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 5)) run_sequence();
			phase++;
		end

		drain();
		if (expect_q.size() != 0)
			report_mismatch("results never delivered, count", 32'(expect_q.size()), '0);
		$display("Sent %0d commands over %0d pick_count settings; checked %0d results.",
			cmds_sent, picks_written, results_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Run-away guard, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
